// ----- rtl/core/iaps_pkg.sv -----
// ----------------------------------------------------------------------------
// iaps_pkg: shared types and constants of the I2C address probe sequencer
// Phase codes, register indexes, reset values and the structs passed between
// the register file, the step logic and the top level.
// ----------------------------------------------------------------------------
package iaps_pkg;

   // configuration register indexes
   localparam int unsigned CsrIdxW = 2;
   localparam logic [CsrIdxW-1:0] CSR_HALF_PERIOD   = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_STRETCH_LIMIT = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_SETTLE_TICKS  = 2'd2;

   localparam int unsigned CfgW = 16;
   localparam logic [CfgW-1:0] HALF_PERIOD_RST   = 16'd5;
   localparam logic [CfgW-1:0] STRETCH_LIMIT_RST = 16'd100;
   localparam logic [CfgW-1:0] SETTLE_TICKS_RST  = 16'd5;
   localparam logic [CfgW-1:0] COUNT_MAX         = 16'hFFFF;

   // probe phases
   localparam int unsigned PhaseW = 4;
   localparam logic [PhaseW-1:0] PH_IDLE      = 4'd0;
   localparam logic [PhaseW-1:0] PH_INIT      = 4'd1;
   localparam logic [PhaseW-1:0] PH_STR_START = 4'd2;
   localparam logic [PhaseW-1:0] PH_START1    = 4'd3;
   localparam logic [PhaseW-1:0] PH_START2    = 4'd4;
   localparam logic [PhaseW-1:0] PH_BITLOW    = 4'd5;
   localparam logic [PhaseW-1:0] PH_BITHIGH   = 4'd6;
   localparam logic [PhaseW-1:0] PH_STR_BIT   = 4'd7;
   localparam logic [PhaseW-1:0] PH_SETTLE    = 4'd8;
   localparam logic [PhaseW-1:0] PH_ACKLOW    = 4'd9;
   localparam logic [PhaseW-1:0] PH_STR_ACK   = 4'd10;
   localparam logic [PhaseW-1:0] PH_ACKHIGH   = 4'd11;
   localparam logic [PhaseW-1:0] PH_STOP0     = 4'd12;
   localparam logic [PhaseW-1:0] PH_STOP1     = 4'd13;
   localparam logic [PhaseW-1:0] PH_STOP2     = 4'd14;
   localparam logic [PhaseW-1:0] PH_STOP3     = 4'd15;

   // item kinds on tuser
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_START = 1'b1;

   localparam int unsigned AddrW     = 7;
   localparam int unsigned BitIdxW   = 4;
   localparam logic [BitIdxW-1:0] FRAME_BITS = 4'd8;

   localparam int unsigned ReqDataW = 16;
   localparam int unsigned RspDataW = 8;

   typedef struct packed {
      logic [CfgW-1:0] half_period;
      logic [CfgW-1:0] stretch_limit;
      logic [CfgW-1:0] settle_ticks;
   } cfg_type;

   typedef struct packed {
      logic             cmd;
      logic [AddrW-1:0] address;
      logic             scl_level;
      logic             sda_level;
   } item_type;

   typedef struct packed {
      logic scl_release;
      logic sda_release;
      logic busy_res;
      logic done_res;
      logic ack_seen;
   } result_type;

endpackage

// ----- rtl/core/iaps_csr.sv -----
// ----------------------------------------------------------------------------
// iaps_csr: configuration registers
// Holds half period, stretch limit and settle time; writes to unused indexes
// are dropped.
// ----------------------------------------------------------------------------
module iaps_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [iaps_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [iaps_pkg::CfgW-1:0]     csr_data,
   output iaps_pkg::cfg_type             cfg
);
   import iaps_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_HALF_PERIOD:   cfg_in.half_period   = csr_data;
            CSR_STRETCH_LIMIT: cfg_in.stretch_limit = csr_data;
            CSR_SETTLE_TICKS:  cfg_in.settle_ticks  = csr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_period   <= HALF_PERIOD_RST;
         cfg_ff.stretch_limit <= STRETCH_LIMIT_RST;
         cfg_ff.settle_ticks  <= SETTLE_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/iaps_fsm.sv -----
// ----------------------------------------------------------------------------
// iaps_fsm: probe state and single-item step logic
// Holds the probe phase, counters and line drive; on each advance it applies
// one item and produces the matching result.
// ----------------------------------------------------------------------------
module iaps_fsm (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  iaps_pkg::item_type    item,
   input  iaps_pkg::cfg_type     cfg,
   output iaps_pkg::result_type  result
);
   import iaps_pkg::*;

   logic [PhaseW-1:0]  phase_ff,  phase_in;
   logic [BitIdxW-1:0] bit_idx_ff, bit_idx_in;
   logic [CfgW-1:0]    wait_ff,   wait_in;
   logic [7:0]         shift_ff,  shift_in;
   logic               ack_ff,    ack_in;
   logic               scl_rel_ff, scl_rel_in;
   logic               sda_rel_ff, sda_rel_in;
   logic               done;

   // saturating tick count and the wait / stretch checks built on it
   logic [CfgW-1:0]    wait_inc;
   logic               half_hit;
   logic               settle_hit;
   logic               stretch_fail;
   logic [BitIdxW-1:0] bit_idx_nxt;
   logic [7:0]         shift_nxt;

   assign wait_inc     = (wait_ff != COUNT_MAX) ? wait_ff + 16'd1 : wait_ff;
   assign half_hit     = (wait_inc >= cfg.half_period);
   assign settle_hit   = (wait_inc >= cfg.settle_ticks);
   assign stretch_fail = (wait_inc >= cfg.stretch_limit);
   assign bit_idx_nxt  = bit_idx_ff + 4'd1;
   assign shift_nxt    = {shift_ff[6:0], 1'b0};

   // next state for one item
   always_comb begin
      phase_in   = phase_ff;
      bit_idx_in = bit_idx_ff;
      wait_in    = wait_ff;
      shift_in   = shift_ff;
      ack_in     = ack_ff;
      scl_rel_in = scl_rel_ff;
      sda_rel_in = sda_rel_ff;
      done       = 1'b0;

      if (item.cmd == CMD_START) begin
         if (phase_ff == PH_IDLE) begin
            shift_in   = {item.address, 1'b0};
            bit_idx_in = '0;
            ack_in     = 1'b0;
            scl_rel_in = 1'b1;
            sda_rel_in = 1'b1;
            phase_in   = PH_INIT;
            wait_in    = '0;
         end
      end else begin
         unique case (phase_ff)
            PH_IDLE: begin
            end
            PH_INIT: begin
               wait_in = wait_inc;
               if (half_hit) begin
                  scl_rel_in = 1'b1;
                  phase_in   = PH_STR_START;
                  wait_in    = '0;
               end
            end
            PH_STR_START: begin
               if (item.scl_level) begin
                  sda_rel_in = 1'b0;
                  phase_in   = PH_START1;
                  wait_in    = '0;
               end else begin
                  wait_in = wait_inc;
                  if (stretch_fail) begin
                     phase_in = PH_STOP0;
                     wait_in  = '0;
                  end
               end
            end
            PH_START1: begin
               wait_in = wait_inc;
               if (half_hit) begin
                  scl_rel_in = 1'b0;
                  phase_in   = PH_START2;
                  wait_in    = '0;
               end
            end
            PH_START2: begin
               wait_in = wait_inc;
               if (half_hit) begin
                  sda_rel_in = shift_ff[7];
                  phase_in   = PH_BITLOW;
                  wait_in    = '0;
               end
            end
            PH_BITLOW: begin
               wait_in = wait_inc;
               if (half_hit) begin
                  scl_rel_in = 1'b1;
                  phase_in   = PH_BITHIGH;
                  wait_in    = '0;
               end
            end
            PH_BITHIGH: begin
               wait_in = wait_inc;
               if (half_hit) begin
                  phase_in = PH_STR_BIT;
                  wait_in  = '0;
               end
            end
            PH_STR_BIT: begin
               if (item.scl_level) begin
                  scl_rel_in = 1'b0;
                  phase_in   = PH_SETTLE;
                  wait_in    = '0;
               end else begin
                  wait_in = wait_inc;
                  if (stretch_fail) begin
                     phase_in = PH_STOP0;
                     wait_in  = '0;
                  end
               end
            end
            PH_SETTLE: begin
               wait_in = wait_inc;
               if (settle_hit) begin
                  bit_idx_in = bit_idx_nxt;
                  shift_in   = shift_nxt;
                  wait_in    = '0;
                  if (bit_idx_nxt < FRAME_BITS) begin
                     sda_rel_in = shift_nxt[7];
                     phase_in   = PH_BITLOW;
                  end else begin
                     sda_rel_in = 1'b1;
                     phase_in   = PH_ACKLOW;
                  end
               end
            end
            PH_ACKLOW: begin
               wait_in = wait_inc;
               if (half_hit) begin
                  scl_rel_in = 1'b1;
                  phase_in   = PH_STR_ACK;
                  wait_in    = '0;
               end
            end
            PH_STR_ACK: begin
               if (item.scl_level) begin
                  ack_in   = ~item.sda_level;
                  phase_in = PH_ACKHIGH;
                  wait_in  = '0;
               end else begin
                  wait_in = wait_inc;
                  if (stretch_fail) begin
                     phase_in = PH_STOP0;
                     wait_in  = '0;
                  end
               end
            end
            PH_ACKHIGH: begin
               wait_in = wait_inc;
               if (half_hit) begin
                  scl_rel_in = 1'b0;
                  phase_in   = PH_STOP0;
                  wait_in    = '0;
               end
            end
            PH_STOP0: begin
               wait_in = wait_inc;
               if (half_hit) begin
                  sda_rel_in = 1'b0;
                  phase_in   = PH_STOP1;
                  wait_in    = '0;
               end
            end
            PH_STOP1: begin
               wait_in = wait_inc;
               if (half_hit) begin
                  scl_rel_in = 1'b1;
                  phase_in   = PH_STOP2;
                  wait_in    = '0;
               end
            end
            PH_STOP2: begin
               wait_in = wait_inc;
               if (half_hit) begin
                  sda_rel_in = 1'b1;
                  phase_in   = PH_STOP3;
                  wait_in    = '0;
               end
            end
            PH_STOP3: begin
               wait_in = wait_inc;
               if (half_hit) begin
                  done     = 1'b1;
                  phase_in = PH_IDLE;
                  wait_in  = '0;
               end
            end
         endcase
      end
   end

   // state update, one item per advance
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         bit_idx_ff <= '0;
         wait_ff    <= '0;
         shift_ff   <= '0;
         ack_ff     <= 1'b0;
         scl_rel_ff <= 1'b1;
         sda_rel_ff <= 1'b1;
      end else if (advance) begin
         phase_ff   <= phase_in;
         bit_idx_ff <= bit_idx_in;
         wait_ff    <= wait_in;
         shift_ff   <= shift_in;
         ack_ff     <= ack_in;
         scl_rel_ff <= scl_rel_in;
         sda_rel_ff <= sda_rel_in;
      end
   end

   // result of the item being applied
   assign result.scl_release = scl_rel_in;
   assign result.sda_release = sda_rel_in;
   assign result.busy_res    = (phase_in != PH_IDLE);
   assign result.done_res    = done;
   assign result.ack_seen    = done & ack_ff;

endmodule

// ----- rtl/core/i2c_address_probe_sequencer.sv -----
// ----------------------------------------------------------------------------
// An item is held in the input register, and its result in the result register.
// Throughput: one item per cycle unless rsp_tready stalls; one probe step per item.
// Every item gives exactly one result; backpressure on rsp_ stalls req_.
// Reset (synchronous, active high): idle, both lines released, registers
// at half_period 5, stretch_limit 100, settle_ticks 5.
// ----------------------------------------------------------------------------
// i2c_address_probe_sequencer: bit-banged I2C address probe engine
// Input register, probe step logic and result register, plus config registers.
// ----------------------------------------------------------------------------
module i2c_address_probe_sequencer (
   input  logic                           clock,
   input  logic                           reset,
   // input items
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [iaps_pkg::ReqDataW-1:0]  req_tdata,  // address[6:0], scl_level, sda_level
   input  logic                           req_tuser,  // cmd
   // result items
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [iaps_pkg::RspDataW-1:0]  rsp_tdata,  // scl_release, sda_release,
                                                      // busy_res, done_res, ack_seen
   // configuration writes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [iaps_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [iaps_pkg::CfgW-1:0]      csr_data
);
   import iaps_pkg::*;

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       in_vld_ff;
   result_type res;
   result_type res_ff;
   logic       out_vld_ff;
   logic       advance;

   iaps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // step the probe when an item is held and the result slot frees up
   assign advance    = in_vld_ff & (~out_vld_ff | rsp_tready);
   assign req_tready = ~in_vld_ff | advance;

   assign item_in.cmd       = req_tuser;
   assign item_in.address   = req_tdata[AddrW-1:0];
   assign item_in.scl_level = req_tdata[AddrW];
   assign item_in.sda_level = req_tdata[AddrW+1];

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready & req_tvalid) begin
         item_ff <= item_in;
      end
   end

   iaps_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {3'b000, res_ff.ack_seen, res_ff.done_res, res_ff.busy_res,
                        res_ff.sda_release, res_ff.scl_release};

endmodule
